// File: rtl/core/rcpcf_pkg.sv
package rcpcf_pkg;

   // Field and storage widths fixed by the item format.
   localparam int PIN_COUNT  = 4;
   localparam int WIDTH_W    = 16;
   localparam int STAMP_W    = 32;
   localparam int RING_DEPTH = 4;
   localparam int SLOT_W     = $clog2(RING_DEPTH);
   localparam int SUM_W      = WIDTH_W + SLOT_W;

   // Default channel count for the top-level parameter.
   localparam int NUM_CHANNELS_DEF = 4;

   // Hysteresis band around the filtered width and the step taken when leaving it.
   localparam logic [WIDTH_W-1:0] BAND_HALF = 16'd3;
   localparam logic [WIDTH_W-1:0] BAND_STEP = 16'd2;
   localparam logic [SUM_W-1:0]   MEAN_ROUND = SUM_W'(RING_DEPTH / 2);

   // Reset values of the pulse window registers.
   localparam logic [WIDTH_W-1:0] PULSE_MIN_RESET = 16'd750;
   localparam logic [WIDTH_W-1:0] PULSE_MAX_RESET = 16'd2250;

   // Register map of the control port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = WIDTH_W;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PULSE_MIN = 1'b0,
      CSR_PULSE_MAX = 1'b1
   } rcpcf_csr_type;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_TICK   = 1'b1
   } rcpcf_kind_type;

   typedef struct packed {
      rcpcf_kind_type       req_type;
      logic [PIN_COUNT-1:0] pin_levels;
      logic [STAMP_W-1:0]   time_us;
   } rcpcf_req_type;

   typedef struct packed {
      logic [WIDTH_W-1:0]   filt_roll;
      logic [WIDTH_W-1:0]   filt_pitch;
      logic [WIDTH_W-1:0]   filt_yaw;
      logic [WIDTH_W-1:0]   filt_throttle;
      logic [PIN_COUNT-1:0] latched_mask;
   } rcpcf_rsp_type;

   // Strobes from the pipeline control to the datapath lanes.
   typedef struct packed {
      logic sample;
      logic tick;
   } rcpcf_ctl_type;

endpackage

// File: rtl/core/rcpcf_capture.sv
module rcpcf_capture #(
   parameter int NUM_CHANNELS = rcpcf_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  rcpcf_pkg::rcpcf_ctl_type                     ctl,
   input  logic [rcpcf_pkg::PIN_COUNT-1:0]              pin_levels,
   input  logic [rcpcf_pkg::STAMP_W-1:0]                time_us,
   input  logic [rcpcf_pkg::WIDTH_W-1:0]                pulse_min,
   input  logic [rcpcf_pkg::WIDTH_W-1:0]                pulse_max,
   output logic [NUM_CHANNELS-1:0][rcpcf_pkg::WIDTH_W-1:0] raw_width,
   output logic [rcpcf_pkg::PIN_COUNT-1:0]              latched_mask
);
   import rcpcf_pkg::*;

   localparam int ACTIVE_CH = (NUM_CHANNELS < PIN_COUNT) ? NUM_CHANNELS : PIN_COUNT;

   logic [PIN_COUNT-1:0] prev_levels_ff;
   logic [PIN_COUNT-1:0] changed;

   assign changed = pin_levels ^ prev_levels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_levels_ff <= '0;
      end else if (ctl.sample) begin
         prev_levels_ff <= pin_levels;
      end
   end

   // Only the low half of the timestamp matters, since the width wraps at 16 bits.
   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
      if (c < ACTIVE_CH) begin : g_pin
         logic [WIDTH_W-1:0] stamp_ff;
         logic [WIDTH_W-1:0] width_ff;
         logic [WIDTH_W-1:0] pulse;
         logic               rise;
         logic               fall;
         logic               in_window;

         assign pulse     = time_us[WIDTH_W-1:0] - stamp_ff;
         assign in_window = (pulse >= pulse_min) && (pulse <= pulse_max);
         assign rise      = ctl.sample && changed[c] && pin_levels[c];
         assign fall      = ctl.sample && changed[c] && !pin_levels[c];

         always_ff @(posedge clock) begin
            if (reset) begin
               stamp_ff <= '0;
               width_ff <= '0;
            end else begin
               if (rise) begin
                  stamp_ff <= time_us[WIDTH_W-1:0];
               end
               if (fall && in_window) begin
                  width_ff <= pulse;
               end
            end
         end

         assign raw_width[c]    = width_ff;
         assign latched_mask[c] = fall && in_window;
      end else begin : g_nopin
         assign raw_width[c] = '0;
      end
   end

   for (genvar m = ACTIVE_CH; m < PIN_COUNT; m++) begin : g_nomask
      assign latched_mask[m] = 1'b0;
   end

endmodule

// File: rtl/core/rcpcf_filter.sv
module rcpcf_filter #(
   parameter int NUM_CHANNELS = rcpcf_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  rcpcf_pkg::rcpcf_ctl_type                        ctl,
   input  logic [NUM_CHANNELS-1:0][rcpcf_pkg::WIDTH_W-1:0] raw_width,
   output logic [NUM_CHANNELS-1:0][rcpcf_pkg::WIDTH_W-1:0] filt_next
);
   import rcpcf_pkg::*;

   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;

   assign slot_in = slot_ff + SLOT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (ctl.tick) begin
         slot_ff <= slot_in;
      end
   end

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
      logic [RING_DEPTH-1:0][WIDTH_W-1:0] hist_ff;
      logic [WIDTH_W-1:0]                 filt_ff;
      logic [SUM_W-1:0]                   sum;
      logic [SUM_W-1:0]                   rounded;
      logic [WIDTH_W-1:0]                 mean;
      logic [WIDTH_W-1:0]                 low_step;
      logic [WIDTH_W-1:0]                 filt_in;

      // The new width takes the slot being written before the sum is formed.
      always_comb begin
         sum = '0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            if (SLOT_W'(i) == slot_in) begin
               sum = sum + SUM_W'(raw_width[c]);
            end else begin
               sum = sum + SUM_W'(hist_ff[i]);
            end
         end
      end

      assign rounded = sum + MEAN_ROUND;
      assign mean    = rounded[SUM_W-1:SLOT_W];

      // Lower threshold is applied first; the upper one sees its outcome.
      assign low_step = (mean < filt_ff - BAND_HALF) ? mean + BAND_STEP : filt_ff;
      assign filt_in  = (mean > low_step + BAND_HALF) ? mean - BAND_STEP : low_step;

      always_ff @(posedge clock) begin
         if (reset) begin
            hist_ff <= '0;
            filt_ff <= '0;
         end else if (ctl.tick) begin
            hist_ff[slot_in] <= raw_width[c];
            filt_ff          <= filt_in;
         end
      end

      assign filt_next[c] = ctl.tick ? filt_in : filt_ff;
   end

endmodule

// File: rtl/core/rc_pulse_capture_filter_top.sv
// Channel   Direction  Handshake                  Payload
// req_      in         req_valid / req_ready      rcpcf_req_type (kind, pin levels, timestamp)
// rsp_      out        rsp_valid / rsp_ready      rcpcf_rsp_type (four widths, latch mask)
// csr_      in         csr_wr_en, csr_index       csr_wdata (pulse_min, pulse_max)
//
// Every accepted item yields exactly one result item. The item waits in the input
// register and moves on into the result register once that is free or being
// drained. One item is accepted per cycle in steady state while the output is not stalled.
// The rate is set by the input register and the result register, with the edge,
// window and ring-mean logic combinational between them.
// Reset is synchronous and active high; it clears all channel state and restores
// the default pulse window. A stalled output holds its item while the input register
// still accepts one more item, and only then is req_ready dropped.
module rc_pulse_capture_filter_top #(
   parameter int NUM_CHANNELS = rcpcf_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  rcpcf_pkg::rcpcf_req_type                req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output rcpcf_pkg::rcpcf_rsp_type                rsp_data,
   input  logic                                    csr_wr_en,
   input  logic [rcpcf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [rcpcf_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import rcpcf_pkg::*;

   // Pulse window registers. Writes must arrive only while idle; not enforced by the block.
   logic [WIDTH_W-1:0] pulse_min_ff;
   logic [WIDTH_W-1:0] pulse_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff <= PULSE_MIN_RESET;
         pulse_max_ff <= PULSE_MAX_RESET;
      end else if (csr_wr_en) begin
         case (rcpcf_csr_type'(csr_index))
            CSR_PULSE_MIN: pulse_min_ff <= csr_wdata[WIDTH_W-1:0];
            CSR_PULSE_MAX: pulse_max_ff <= csr_wdata[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Result register state, needed by the input side's flow control.
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rcpcf_rsp_type rsp_data_ff;

   // Input register. It refills in the same cycle its item moves on, so the
   // input side keeps flowing while the result register is being drained.
   logic          s1_valid_ff;
   logic          s1_valid_in;
   rcpcf_req_type s1_item_ff;
   logic          advance;
   logic          req_fire;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_data;
      end
   end

   // Item strobes: state is updated exactly when the item moves into the
   // result register, so items are processed strictly in order.
   rcpcf_ctl_type ctl;

   assign ctl.sample = advance && (s1_item_ff.req_type == KIND_SAMPLE);
   assign ctl.tick   = advance && (s1_item_ff.req_type == KIND_TICK);

   logic [NUM_CHANNELS-1:0][WIDTH_W-1:0] raw_width;
   logic [NUM_CHANNELS-1:0][WIDTH_W-1:0] filt_next;
   logic [PIN_COUNT-1:0]                 latched_mask;

   rcpcf_capture #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_capture (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .pin_levels   (s1_item_ff.pin_levels),
      .time_us      (s1_item_ff.time_us),
      .pulse_min    (pulse_min_ff),
      .pulse_max    (pulse_max_ff),
      .raw_width    (raw_width),
      .latched_mask (latched_mask)
   );

   rcpcf_filter #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_filter (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .raw_width (raw_width),
      .filt_next (filt_next)
   );

   // Only the first four channels have output fields; missing ones read as zero.
   logic [PIN_COUNT-1:0][WIDTH_W-1:0] out_width;

   for (genvar j = 0; j < PIN_COUNT; j++) begin : g_out
      if (j < NUM_CHANNELS) begin : g_used
         assign out_width[j] = filt_next[j];
      end else begin : g_unused
         assign out_width[j] = '0;
      end
   end

   rcpcf_rsp_type rsp_item;

   assign rsp_item.filt_roll     = out_width[0];
   assign rsp_item.filt_pitch    = out_width[1];
   assign rsp_item.filt_yaw      = out_width[2];
   assign rsp_item.filt_throttle = out_width[3];
   assign rsp_item.latched_mask  = latched_mask;

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/rcpcf_checker.sv
module rcpcf_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input rcpcf_pkg::rcpcf_rsp_type rsp_data
);
   import rcpcf_pkg::*;

   // Items accepted but not yet delivered; the block holds at most two.
   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic       in_fire;
   logic       out_fire;

   assign in_fire  = req_valid && req_ready;
   assign out_fire = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (in_fire && !out_fire) begin
         pending_in = pending_ff + 2'd1;
      end else if (out_fire && !in_fire) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result item shown with no item outstanding");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more items outstanding than the pipeline holds");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while the result side is free");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or dropped");

endmodule

bind rc_pulse_capture_filter_top rcpcf_checker u_rcpcf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: bench/testbench.sv
// Testbench for rc_pulse_capture_filter_top.
//
// The sequencer (the main initial block) fills a queue of pin-sample and tick
// items, one phase at a time. A clocked driver presents them on the req_
// channel with random gaps. A clocked monitor takes results on the rsp_
// channel with random stalls. Every accepted item is run through a local
// model of the capture and smoothing logic, and the predicted result is
// queued. Each result that comes out is then checked field by field against
// the oldest prediction.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rcpcf_pkg::*;

   localparam int NUM_CH      = NUM_CHANNELS_DEF;
   localparam int ACTIVE_CH   = (NUM_CH < 4) ? NUM_CH : 4;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 215;
   localparam int NUM_PHASES  = 8;
   localparam int MAX_PRINTED = 50;

   // Hysteresis of the smoothing stage: the band half width and the step
   // taken toward the mean when the mean leaves the band.
   localparam logic [15:0] HYST_BAND = 16'd3;
   localparam logic [15:0] HYST_STEP = 16'd2;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   rcpcf_req_type          req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rcpcf_rsp_type          rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   rc_pulse_capture_filter_top #(
      .NUM_CHANNELS(NUM_CH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Items waiting to be driven, and the results owed by the block for the
   // items it has already taken.
   rcpcf_req_type rc_items_queued[$];
   rcpcf_rsp_type width_reports_due[$];

   int  cycle_count = 0;
   int  error_count = 0;
   bit  send_gaps   = 1'b1;
   bit  recv_stalls = 1'b1;

   // Local copy of the block's state and pulse window.
   logic [3:0]  last_levels;
   logic [31:0] edge_stamp   [NUM_CH];
   logic [15:0] held_width   [NUM_CH];
   logic [15:0] width_ring   [NUM_CH][4];
   logic [1:0]  ring_pos;
   logic [15:0] smooth_width [NUM_CH];
   logic [15:0] win_lo;
   logic [15:0] win_hi;

   // Generator side: the pin levels that the last queued sample left behind.
   logic [3:0]  gen_levels = 4'h0;
   int          queued_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED)
         $display("ERROR cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic void clear_capture_state();
      last_levels = 4'h0;
      ring_pos    = 2'd0;
      win_lo      = PULSE_MIN_RESET;
      win_hi      = PULSE_MAX_RESET;
      for (int c = 0; c < NUM_CH; c++) begin
         edge_stamp[c]   = 32'h0;
         held_width[c]   = 16'h0;
         smooth_width[c] = 16'h0;
         for (int i = 0; i < 4; i++)
            width_ring[c][i] = 16'h0;
      end
   endfunction

   // Runs one item through the capture and smoothing logic and returns the
   // result the block must report for it.
   function automatic rcpcf_rsp_type capture_filter_step(input rcpcf_req_type item);
      logic [3:0]  changed;
      logic [3:0]  latched;
      logic [15:0] span;
      logic [17:0] ring_sum;
      logic [15:0] mean;
      logic [15:0] f;
      logic [15:0] low_mark;
      logic [15:0] high_mark;
      logic [15:0] shown [4];
      rcpcf_rsp_type res;
      latched = 4'h0;
      if (item.req_type == KIND_TICK) begin
         // Ticks ignore the pins and the timestamp entirely.
         ring_pos = ring_pos + 2'd1;
         for (int c = 0; c < NUM_CH; c++) begin
            width_ring[c][ring_pos] = held_width[c];
            ring_sum = 18'd0;
            for (int i = 0; i < 4; i++)
               ring_sum = ring_sum + {2'b00, width_ring[c][i]};
            ring_sum = ring_sum + 18'd2;
            mean = ring_sum[17:2];
            // The low test applies first, and the high test sees its outcome.
            // Both band edges wrap at 16 bits.
            f = smooth_width[c];
            low_mark = f - HYST_BAND;
            if (mean < low_mark)
               f = mean + HYST_STEP;
            high_mark = f + HYST_BAND;
            if (mean > high_mark)
               f = mean - HYST_STEP;
            smooth_width[c] = f;
         end
      end else begin
         changed = item.pin_levels ^ last_levels;
         last_levels = item.pin_levels;
         for (int c = 0; c < ACTIVE_CH; c++) begin
            if (changed[c]) begin
               if (item.pin_levels[c]) begin
                  edge_stamp[c] = item.time_us;
               end else begin
                  span = 16'(item.time_us - edge_stamp[c]);
                  if (span >= win_lo && span <= win_hi) begin
                     held_width[c] = span;
                     latched[c] = 1'b1;
                  end
               end
            end
         end
      end
      for (int j = 0; j < 4; j++)
         shown[j] = (j < NUM_CH) ? smooth_width[j] : 16'h0;
      res.filt_roll     = shown[0];
      res.filt_pitch    = shown[1];
      res.filt_yaw      = shown[2];
      res.filt_throttle = shown[3];
      res.latched_mask  = latched;
      return res;
   endfunction

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_pause(input bit enabled);
      int r;
      r = $urandom_range(99);
      if (!enabled || r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(3, 1);
      if (r < 97)
         return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   // Driver. A new item goes out, after any gap, when the bus is empty or the current one
   // was taken at this edge; otherwise valid and payload are held.
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         clear_capture_state();
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && req_ready)
            width_reports_due.push_back(capture_filter_step(req_data));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (rc_items_queued.size() > 0) begin
               req_data  <= rc_items_queued.pop_front();
               req_valid <= 1'b1;
               gap_left  <= pick_pause(send_gaps);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Ready is raised and then dropped for a random stall, which may be of zero length.
   int stall_left = 0;

   always @(posedge clock) begin
      rcpcf_rsp_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (width_reports_due.size() == 0) begin
               report_mismatch($sformatf("result with none expected: %h", rsp_data));
            end else begin
               want = width_reports_due.pop_front();
               if (rsp_data.filt_roll !== want.filt_roll)
                  report_mismatch($sformatf("filt_roll got %0d expected %0d",
                                            rsp_data.filt_roll, want.filt_roll));
               if (rsp_data.filt_pitch !== want.filt_pitch)
                  report_mismatch($sformatf("filt_pitch got %0d expected %0d",
                                            rsp_data.filt_pitch, want.filt_pitch));
               if (rsp_data.filt_yaw !== want.filt_yaw)
                  report_mismatch($sformatf("filt_yaw got %0d expected %0d",
                                            rsp_data.filt_yaw, want.filt_yaw));
               if (rsp_data.filt_throttle !== want.filt_throttle)
                  report_mismatch($sformatf("filt_throttle got %0d expected %0d",
                                            rsp_data.filt_throttle, want.filt_throttle));
               if (rsp_data.latched_mask !== want.latched_mask)
                  report_mismatch($sformatf("latched_mask got %h expected %h",
                                            rsp_data.latched_mask, want.latched_mask));
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready  <= 1'b1;
            stall_left <= pick_pause(recv_stalls);
         end
      end
   end

   task automatic queue_sample(input logic [3:0] levels, input logic [31:0] stamp);
      rcpcf_req_type item;
      item.req_type   = KIND_SAMPLE;
      item.pin_levels = levels;
      item.time_us    = stamp;
      rc_items_queued.push_back(item);
      gen_levels = levels;
      queued_count++;
   endtask

   // The pins and timestamp of a tick are don't-care, so random values go
   // along to show that the block ignores them.
   task automatic queue_tick(input logic [3:0] levels, input logic [31:0] stamp);
      rcpcf_req_type item;
      item.req_type   = KIND_TICK;
      item.pin_levels = levels;
      item.time_us    = stamp;
      rc_items_queued.push_back(item);
      queued_count++;
   endtask

   // Pulse length for one channel of a frame, aimed at the current window:
   // inside it, on its edges, just outside it, or anywhere. Sometimes the
   // upper timestamp bits are disturbed too, which only the low 16 bits of
   // the elapsed time must survive.
   function automatic logic [31:0] pick_span();
      logic [15:0] w;
      int r;
      r = $urandom_range(99);
      if (win_lo <= win_hi && r < 60)
         w = 16'($urandom_range(win_hi, win_lo));
      else if (r < 70)
         w = win_lo;
      else if (r < 80)
         w = win_hi;
      else if (r < 85)
         w = win_lo - 16'd1;
      else if (r < 90)
         w = win_hi + 16'd1;
      else
         w = 16'($urandom);
      if ($urandom_range(9) == 0)
         return {16'($urandom), w};
      return {16'h0, w};
   endfunction

   // One receiver frame: some channels rise together, then fall one by one
   // (sometimes the rest at once), followed by the usual filter tick.
   task automatic queue_frame();
      logic [31:0] t0;
      logic [3:0]  rise_mask;
      logic [3:0]  lv;
      int          ticks;
      if (gen_levels != 4'h0)
         queue_sample(4'h0, $urandom);
      if ($urandom_range(7) == 0)
         t0 = 32'hFFFF_FFFF - 32'($urandom_range(3000));
      else
         t0 = $urandom;
      rise_mask = ($urandom_range(3) == 0) ? 4'($urandom) : 4'hF;
      queue_sample(rise_mask, t0);
      lv = rise_mask;
      for (int c = 0; c < 4; c++) begin
         if (lv[c]) begin
            lv[c] = 1'b0;
            if (c < 3 && $urandom_range(5) == 0)
               lv = 4'h0;
            queue_sample(lv, t0 + pick_span());
         end
      end
      ticks = ($urandom_range(9) == 0) ? $urandom_range(3) : 1;
      repeat (ticks) queue_tick(4'($urandom), $urandom);
   endtask

   // Lets every queued item go out and every result come back, then lets the
   // pipeline settle.
   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (rc_items_queued.size() != 0 || req_valid || width_reports_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input rcpcf_csr_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PULSE_MIN: win_lo = value;
         CSR_PULSE_MAX: win_hi = value;
         default: ;
      endcase
   endtask

   // Window settings per phase: defaults, the widest window, a single legal
   // width, an empty window (min above max), the two extreme single widths,
   // a random window, and the defaults again written explicitly.
   logic [15:0] phase_min [NUM_PHASES] =
      '{16'd750, 16'd0, 16'd1000, 16'd2000, 16'd65535, 16'd0, 16'd0, 16'd750};
   logic [15:0] phase_max [NUM_PHASES] =
      '{16'd2250, 16'd65535, 16'd1000, 16'd1000, 16'd65535, 16'd0, 16'd0, 16'd2250};

   initial begin
      logic [15:0] lo;
      logic [15:0] hi;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items, under the default 750..2250 window.
      // A tick straight after reset, with every ignored field set.
      queue_tick(4'hF, 32'hFFFF_FFFF);
      // All channels rise; roll falls at exactly the minimum, pitch at the
      // maximum, yaw one below the minimum and throttle one above the maximum.
      queue_sample(4'hF, 32'd100);
      queue_sample(4'hE, 32'd850);
      queue_sample(4'hC, 32'd2350);
      queue_sample(4'h8, 32'd849);
      queue_sample(4'h0, 32'd2351);
      queue_tick(4'h0, 32'h0);
      // A roll pulse across the timestamp wrap.
      queue_sample(4'h1, 32'hFFFF_FF00);
      queue_sample(4'h0, 32'h0000_0400);
      // A pitch pulse whose elapsed time exceeds 16 bits; the low half counts.
      queue_sample(4'h2, 32'd1000);
      queue_sample(4'h0, 32'd1000 + 32'h0001_0000 + 32'd1500);
      // Same levels again: no edge at all.
      queue_sample(4'h0, 32'd5);
      repeat (3) queue_tick(4'h5, 32'hA5A5_5A5A);
      // All channels fall together.
      queue_sample(4'hF, 32'h8000_0000);
      queue_sample(4'h0, 32'h8000_0000 + 32'd2000);
      repeat (4) queue_tick(4'hA, 32'h5A5A_A5A5);
      // Alternating channels: a fall on two and a rise on the other two at once.
      queue_sample(4'h5, 32'h0001_0000);
      queue_sample(4'hA, 32'h0001_0000 + 32'd1200);
      queue_sample(4'h0, 32'h0001_0000 + 32'd2400);
      queue_tick(4'h0, 32'h0);
      // The sender holds back here until every result is in.
      wait_until_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            lo = phase_min[p];
            hi = phase_max[p];
            if (p == 6) begin
               lo = 16'($urandom_range(3000));
               hi = lo + 16'($urandom_range(3000));
            end
            csr_write(CSR_PULSE_MIN, lo);
            csr_write(CSR_PULSE_MAX, hi);
            @(posedge clock);
            csr_wr_en <= 1'b0;
         end
         // Some phases run with no gaps on one side, and one phase on both.
         send_gaps   = (p != 2) && (p != 5);
         recv_stalls = (p != 3) && (p != 5);
         @(negedge clock);
         queued_count = 0;
         // Mostly well-formed frames; the rest is random ticks and random pin samples.
         while (queued_count < PHASE_ITEMS) begin
            if ($urandom_range(99) < 85)
               queue_frame();
            else if ($urandom_range(1) == 1)
               queue_tick(4'($urandom), $urandom);
            else
               queue_sample(4'($urandom), $urandom);
         end
         wait_until_drained();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/core/rcpcf_pkg.sv
rtl/core/rcpcf_capture.sv
rtl/core/rcpcf_filter.sv
rtl/core/rc_pulse_capture_filter_top.sv
rtl/core/rcpcf_checker.sv
bench/testbench.sv
